[hw/rtl/hsi_pkg.sv]
`default_nettype none
package hsi_pkg;

    localparam int TQ = 52;
    localparam int TW = TQ + 1;
    localparam int TSPLIT = 26;
    localparam int NDEG = 181;
    localparam int NREG = 6;
    localparam logic [24:0] INTEN_MUL = 25'd17544900;
    localparam int INTEN_SH = 27;

    typedef enum logic [2:0] {
        REG_HUE_MIN   = 3'd0,
        REG_HUE_MAX   = 3'd1,
        REG_SAT_MIN   = 3'd2,
        REG_SAT_MAX   = 3'd3,
        REG_INTEN_MIN = 3'd4,
        REG_INTEN_MAX = 3'd5
    } t_reg_idx;

    typedef logic [TW-1:0] t_thr_tab [0:NDEG-1];

    typedef struct packed {
        logic        n_neg;
        logic        n_le0;
        logic [17:0] n2;
        logic [19:0] d4;
        logic        b_gt_g;
        logic        hue_en;
        logic        grey;
        logic [9:0]  s;
        logic [16:0] rem;
        logic [6:0]  quo;
        logic [6:0]  inten;
        logic [7:0]  lo;
    } t_item;

    typedef struct packed {
        logic [8:0] hue_min;
        logic [8:0] hue_max;
        logic [6:0] sat_min;
        logic [6:0] sat_max;
        logic [6:0] inten_min;
        logic [6:0] inten_max;
    } t_cfg;

    // squared cosine of each whole degree, Q52
    function automatic t_thr_tab thr_build();
        t_thr_tab t;
        real c;
        for (int d = 0; d < NDEG; d++) begin
            c = $cos(d * 3.1415926 / 180.0);
            t[d] = TW'(longint'(c * c * (2.0 ** TQ)));
        end
        return t;
    endfunction

    localparam t_thr_tab THR_SQ = thr_build();

endpackage
`default_nettype wire

[hw/rtl/hsi_colour_threshold_mask_top.sv]
// Channel  | Dir | Fields
// s_axis   | in  | tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
// m_axis   | out | tdata: mask_hit[0], hue_deg[9:1], sat_pct[16:10], inten_pct[23:17]
// apb      | in  | six window registers at 0x00..0x14
// One pixel per cycle while the output is not stalled; pipeline of two prep stages,
// eight two-stage binary search steps over the cosine table and one output stage.
// Synchronous active-low reset clears valids and loads default windows.
// A stalled output freezes the whole pipe; nothing is lost or repeated.
`default_nettype none
module hsi_colour_threshold_mask_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red_in, green_in, blue_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // mask_hit, hue_deg, sat_pct, inten_pct
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    hsi_pkg::t_cfg  r_cfg;
    logic           en;
    logic [2:0]     idx;
    hsi_pkg::t_item item [0:8];
    logic           vld  [0:8];

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign pready     = 1'b1;
    assign idx        = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_min   <= 9'd45;
            r_cfg.hue_max   <= 9'd60;
            r_cfg.sat_min   <= 7'd17;
            r_cfg.sat_max   <= 7'd100;
            r_cfg.inten_min <= 7'd19;
            r_cfg.inten_max <= 7'd99;
        end else if (psel && penable && pwrite) begin
            case (idx)
                hsi_pkg::REG_HUE_MIN:   r_cfg.hue_min   <= pwdata[8:0];
                hsi_pkg::REG_HUE_MAX:   r_cfg.hue_max   <= pwdata[8:0];
                hsi_pkg::REG_SAT_MIN:   r_cfg.sat_min   <= pwdata[6:0];
                hsi_pkg::REG_SAT_MAX:   r_cfg.sat_max   <= pwdata[6:0];
                hsi_pkg::REG_INTEN_MIN: r_cfg.inten_min <= pwdata[6:0];
                hsi_pkg::REG_INTEN_MAX: r_cfg.inten_max <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hsi_pkg::REG_HUE_MIN:   prdata = 32'(r_cfg.hue_min);
            hsi_pkg::REG_HUE_MAX:   prdata = 32'(r_cfg.hue_max);
            hsi_pkg::REG_SAT_MIN:   prdata = 32'(r_cfg.sat_min);
            hsi_pkg::REG_SAT_MAX:   prdata = 32'(r_cfg.sat_max);
            hsi_pkg::REG_INTEN_MIN: prdata = 32'(r_cfg.inten_min);
            hsi_pkg::REG_INTEN_MAX: prdata = 32'(r_cfg.inten_max);
            default:                prdata = '0;
        endcase
    end

    hsi_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_item  (item[0]),
        .o_vld   (vld[0])
    );

    for (genvar k = 0; k < 8; k++) begin : g_step
        hsi_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (3'(7 - k)),
            .i_vld   (vld[k]),
            .i_item  (item[k]),
            .o_vld   (vld[k+1]),
            .o_item  (item[k+1])
        );
    end

    hsi_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (vld[8]),
        .i_item  (item[8]),
        .i_cfg   (r_cfg),
        .o_vld   (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

endmodule
`default_nettype wire

[hw/rtl/hsi_prep.sv]
`default_nettype none
module hsi_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [7:0]    i_red,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_blue,
    output hsi_pkg::t_item     o_item,
    output logic               o_vld
);

    logic              r_v1;
    logic signed [9:0] r_rg, r_rb, r_gb;
    logic signed [10:0] r_n;
    logic [9:0]        r_s, r_diff;
    logic              r_grey, r_bg;
    logic              r_v2;
    hsi_pkg::t_item    r_item;

    logic [7:0]  mn, mx;
    logic [9:0]  s;
    logic signed [19:0] dd;
    logic [16:0] p;
    logic [34:0] iprod;
    hsi_pkg::t_item n_item;

    always_comb begin
        mn = (i_red < i_green) ? i_red : i_green;
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue < mn) mn = i_blue;
        if (i_blue > mx) mx = i_blue;
        s = 10'(i_red) + 10'(i_green) + 10'(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rg   <= $signed({2'b0, i_red}) - $signed({2'b0, i_green});
            r_rb   <= $signed({2'b0, i_red}) - $signed({2'b0, i_blue});
            r_gb   <= $signed({2'b0, i_green}) - $signed({2'b0, i_blue});
            r_n    <= $signed({2'b0, i_red, 1'b0}) - $signed({3'b0, i_green})
                      - $signed({3'b0, i_blue});
            r_s    <= s;
            r_diff <= s - 10'(3 * mn);
            r_grey <= (mx == mn);
            r_bg   <= (i_blue > i_green);
            r_item <= n_item;
        end
    end

    always_comb begin
        dd    = 20'(r_rg * r_rg) + 20'(r_rb * r_gb);
        p     = 17'(r_diff) * 17'd100;
        iprod = 35'(r_s) * 35'(hsi_pkg::INTEN_MUL);
        n_item        = '0;
        n_item.n_neg  = r_n < 0;
        n_item.n_le0  = r_n <= 0;
        n_item.n2     = 18'(r_n * r_n);
        n_item.d4     = {dd[17:0], 2'b00};
        n_item.b_gt_g = r_bg;
        n_item.grey   = r_grey;
        n_item.hue_en = !r_grey && (p > 17'(r_s));
        n_item.s      = r_s;
        n_item.rem    = p;
        n_item.inten  = 7'(iprod >> hsi_pkg::INTEN_SH);
    end

    assign o_item = r_item;
    assign o_vld  = r_v2;

endmodule
`default_nettype wire

[hw/rtl/hsi_step.sv]
`default_nettype none
module hsi_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic [2:0]     i_bit,
    input  wire logic           i_vld,
    input  wire hsi_pkg::t_item i_item,
    output logic                o_vld,
    output hsi_pkg::t_item      o_item
);

    localparam int HW = hsi_pkg::TW - hsi_pkg::TSPLIT;

    logic              r_va, r_vb;
    hsi_pkg::t_item    r_ia, r_ib;
    logic [19+HW:0]    r_pph;
    logic [19+hsi_pkg::TSPLIT:0] r_ppl;
    logic [7:0]        r_cand;
    logic              r_cok, r_tneg;

    logic [7:0]        cand;
    logic [hsi_pkg::TW-1:0] t;
    logic [72:0]       prod, lhs;
    logic              ok;
    logic [2:0]        dk;
    logic [16:0]       sub;
    hsi_pkg::t_item    n_ib;

    always_comb begin
        cand = i_item.lo | (8'd1 << i_bit);
        t    = (cand < 8'(hsi_pkg::NDEG)) ? hsi_pkg::THR_SQ[cand] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ia   <= i_item;
            r_pph  <= (20 + HW)'(i_item.d4) * (20 + HW)'(t[hsi_pkg::TW-1:hsi_pkg::TSPLIT]);
            r_ppl  <= (20 + hsi_pkg::TSPLIT)'(i_item.d4)
                      * (20 + hsi_pkg::TSPLIT)'(t[hsi_pkg::TSPLIT-1:0]);
            r_cand <= cand;
            r_cok  <= cand < 8'(hsi_pkg::NDEG);
            r_tneg <= cand > 8'd90;
            r_ib   <= n_ib;
        end
    end

    always_comb begin
        prod = (73'(r_pph) << hsi_pkg::TSPLIT) + 73'(r_ppl);
        lhs  = 73'(r_ia.n2) << hsi_pkg::TQ;
        if (r_tneg) ok = r_ia.n_neg && (lhs >= prod);
        else        ok = r_ia.n_le0 || (lhs <= prod);
        n_ib = r_ia;
        if (r_cok && ok) n_ib.lo = r_cand;
        dk  = i_bit - 3'd1;
        sub = 17'(r_ia.s) << dk;
        if (i_bit != 3'd0 && r_ia.rem >= sub) begin
            n_ib.rem = r_ia.rem - sub;
            n_ib.quo = r_ia.quo | (7'd1 << dk);
        end
    end

    assign o_vld  = r_vb;
    assign o_item = r_ib;

endmodule
`default_nettype wire

[hw/rtl/hsi_out.sv]
`default_nettype none
module hsi_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire hsi_pkg::t_item i_item,
    input  wire hsi_pkg::t_cfg  i_cfg,
    output logic                o_vld,
    output logic [23:0]         o_data
);

    logic        r_vld;
    logic [23:0] r_data;
    logic [8:0]  hue;
    logic [6:0]  sat;
    logic        hit;

    always_comb begin
        if (!i_item.hue_en)     hue = '0;
        else if (i_item.b_gt_g) hue = 9'd359 - 9'(i_item.lo);
        else                    hue = 9'(i_item.lo);
        sat = i_item.grey ? 7'd0 : i_item.quo;
        hit = hue >= i_cfg.hue_min && hue <= i_cfg.hue_max
              && sat >= i_cfg.sat_min && sat <= i_cfg.sat_max
              && i_item.inten >= i_cfg.inten_min && i_item.inten <= i_cfg.inten_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (i_en) r_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= {i_item.inten, sat, hue, hit};
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

[hw/rtl/hsi_chk.sv]
`default_nettype none
module hsi_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready) else $error("input stalled with empty output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled beat changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[9:1] <= 9'd359 && o_m_tdata[16:10] <= 7'd100
        && o_m_tdata[23:17] <= 7'd100) else $error("field out of range");

    a_low_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[16:10] == 7'd0 |-> o_m_tdata[9:1] == 9'd0)
        else $error("hue set on unsaturated pixel");

endmodule

bind hsi_colour_threshold_mask_top hsi_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

[test/hsi_mask_checker.sv]
`default_nettype none
module hsi_mask_checker
    import hsi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [4:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);

    // laid out as the output beat, hit in bit 0
    typedef struct packed {
        logic [6:0] inten;
        logic [6:0] sat;
        logic [8:0] hue;
        logic       hit;
    } t_pix_res;

    logic [63:0] cos_sq [0:180];
    logic        cos_neg [0:180];
    t_cfg        win;
    t_pix_res    pix_q[$];

    function automatic logic [63:0] q59_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[122:59];
    endfunction

    // cos(d * 3.1415926/180) via truncated Taylor series in Q59
    initial begin
        logic [127:0] num;
        logic [63:0]  x, term, mag;
        longint       acc;
        for (int d = 0; d <= 180; d++) begin
            num  = (128'(d) * 128'd31415926) << 59;
            x    = 64'(num / 128'd1800000000);
            term = 64'd1 << 59;
            acc  = longint'(term);
            for (int k = 1; k <= 40 && term != 0; k++) begin
                term = q59_mul(term, x) / 64'(2 * k - 1);
                term = q59_mul(term, x) / 64'(2 * k);
                if (k & 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            cos_neg[d] = acc < 0;
            mag = acc < 0 ? 64'(-acc) : 64'(acc);
            cos_sq[d] = q59_mul(mag, mag);
        end
    end

    function automatic t_pix_res hsi_of_pixel(logic [23:0] px, t_cfg w);
        t_pix_res     res;
        int           r, g, b, mn, mx, s, diff, n, dd, a;
        logic [127:0] lhs, rhs;
        logic [63:0]  d4;
        bit           ok;
        r = int'(px[7:0]);
        g = int'(px[15:8]);
        b = int'(px[23:16]);
        mn = r < g ? r : g;
        mn = mn < b ? mn : b;
        mx = r > g ? r : g;
        mx = mx > b ? mx : b;
        s = r + g + b;
        res.inten = 7'((100 * s) / 765);
        res.sat = 0;
        res.hue = 0;
        if (mx != mn) begin
            diff = s - 3 * mn;
            res.sat = 7'((100 * diff) / s);
            if (100 * diff > s) begin
                n = 2 * r - g - b;
                dd = (r - g) * (r - g) + (r - b) * (g - b);
                d4 = 64'(4 * dd);
                lhs = 128'(n * n) << 59;
                a = 0;
                for (int d = 1; d <= 180; d++) begin
                    rhs = {64'd0, d4} * {64'd0, cos_sq[d]};
                    if (!cos_neg[d])
                        ok = (n <= 0) || (lhs <= rhs);
                    else
                        ok = (n < 0) && (lhs >= rhs);
                    if (!ok)
                        break;
                    a = d;
                end
                res.hue = 9'((b <= g) ? a : 359 - a);
            end
        end
        res.hit = res.hue >= w.hue_min && res.hue <= w.hue_max &&
                  res.sat >= w.sat_min && res.sat <= w.sat_max &&
                  res.inten >= w.inten_min && res.inten <= w.inten_max;
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pix_res got, want;
        if (!i_rst_n) begin
            win <= '{hue_min: 9'd45, hue_max: 9'd60, sat_min: 7'd17, sat_max: 7'd100,
                     inten_min: 7'd19, inten_max: 7'd99};
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_HUE_MIN:   win.hue_min   <= i_pwdata[8:0];
                    REG_HUE_MAX:   win.hue_max   <= i_pwdata[8:0];
                    REG_SAT_MIN:   win.sat_min   <= i_pwdata[6:0];
                    REG_SAT_MAX:   win.sat_max   <= i_pwdata[6:0];
                    REG_INTEN_MIN: win.inten_min <= i_pwdata[6:0];
                    REG_INTEN_MAX: win.inten_max <= i_pwdata[6:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                pix_q.push_back(hsi_of_pixel(i_s_tdata, win));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (pix_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, i_m_tdata);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pix_q.pop_front();
                    if (got.hit != want.hit || got.hue != want.hue ||
                        got.sat != want.sat || got.inten != want.inten) begin
                        $display("%0t: mismatch, expected hit %0d hue %0d sat %0d inten %0d,",
                                 $time, want.hit, want.hue, want.sat, want.inten,
                                 " actual hit %0d hue %0d sat %0d inten %0d",
                                 got.hit, got.hue, got.sat, got.inten);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = pix_q.size();
        end
    end

endmodule
`default_nettype wire

[test/hsi_colour_threshold_mask_top_tb.sv]
`default_nettype none
module hsi_colour_threshold_mask_top_tb;
    import hsi_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [23:0] i_s_tdata = '0;
    logic        i_m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_s_tready, o_m_tvalid, pready;
    logic [23:0] o_m_tdata;
    logic [31:0] prdata;
    int          fail_count, pending;
    bit          no_gaps = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    hsi_colour_threshold_mask_top i_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .o_m_tvalid, .i_m_tready, .o_m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    hsi_mask_checker i_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #(12 * 300000);
        $display("simulation failed");
        $finish;
    end

    // result sink, with one long hold-off to back the pipe up
    initial begin
        int n, beats;
        bit held;
        beats = 0;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        i_m_tready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!o_m_tvalid);
            beats++;
            n = no_gaps ? 0 : $urandom_range(0, 11);
            if (!held && beats == 60) begin
                n = 150;
                held = 1;
            end
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 11);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {b, g, r};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic reg_write(logic [4:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_windows(int hmin, int hmax, int smin, int smax, int imin, int imax);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        reg_write({REG_HUE_MIN, 2'b00}, hmin);
        reg_write({REG_HUE_MAX, 2'b00}, hmax);
        reg_write({REG_SAT_MIN, 2'b00}, smin);
        reg_write({REG_SAT_MAX, 2'b00}, smax);
        reg_write({REG_INTEN_MIN, 2'b00}, imin);
        reg_write({REG_INTEN_MAX, 2'b00}, imax);
    endtask

    task automatic random_pixels(int count);
        int kind;
        logic [7:0] r, g, b;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            if (kind == 0) begin
                g = r + 8'($urandom_range(0, 3));
                b = r + 8'($urandom_range(0, 3));
            end else if (kind == 1) begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            if (i % 40 == 0)
                no_gaps = $urandom_range(0, 2) == 0;
            send_pixel(r, g, b);
        end
        no_gaps = 0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd200, 8'd0);
        send_pixel(8'd200, 8'd200, 8'd201);
        send_pixel(8'd200, 8'd201, 8'd200);
        send_pixel(8'd100, 8'd100, 8'd101);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd2);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd10, 8'd0, 8'd11);
        send_pixel(8'd200, 8'd150, 8'd40);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);

        random_pixels(60);
        set_windows(0, 360, 0, 100, 0, 100);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        random_pixels(70);
        set_windows(511, 0, 127, 0, 127, 0);
        random_pixels(40);
        set_windows(0, 511, 0, 127, 0, 127);
        reg_write(5'(NREG * 4), 32'hffff_ffff);
        reg_write(5'(NREG * 4 + 4), 32'h0);
        random_pixels(60);
        for (int p = 0; p < 4; p++) begin
            set_windows($urandom_range(0, 359), $urandom_range(0, 511),
                        $urandom_range(0, 60), $urandom_range(40, 127),
                        $urandom_range(0, 60), $urandom_range(40, 127));
            random_pixels(40);
        end
        set_windows($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_pixels(30);
        set_windows(45, 60, 17, 100, 19, 99);
        random_pixels(30);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

[hsi_colour_threshold_mask_top.f]
hw/rtl/hsi_pkg.sv
hw/rtl/hsi_prep.sv
hw/rtl/hsi_step.sv
hw/rtl/hsi_out.sv
hw/rtl/hsi_colour_threshold_mask_top.sv
hw/rtl/hsi_chk.sv
test/hsi_mask_checker.sv
test/hsi_colour_threshold_mask_top_tb.sv
